// ----- hdl/fsa_pkg.sv -----
`timescale 1ns / 1ps
// fsa_pkg: shared types, register indexes and binary32 helpers for float_scale_offset.
// Used by fsa_mul, fsa_add, the top level and the checker; no dependencies.
package fsa_pkg;

	localparam logic [31:0] QNAN      = 32'h7FC0_0000;
	localparam logic [31:0] SCALE_RST = 32'h3F80_0000;
	localparam logic [31:0] OFFSET_RST = 32'h0000_0000;
	localparam int          CfgIdxW   = 8;
	localparam logic [CfgIdxW-1:0] REG_SCALE  = 8'd0;
	localparam logic [CfgIdxW-1:0] REG_OFFSET = 8'd1;

	typedef struct packed {
		logic [31:0] element_value;
		logic        element_last;
	} element_t;

	typedef struct packed {
		logic [31:0] result_value;
		logic        result_last;
	} result_t;

	// finite operand as sig * 2^e
	typedef struct packed {
		logic [23:0]        sig;
		logic signed [11:0] e;
	} fin_t;

	function automatic logic is_nan(input logic [31:0] b);
		return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
	endfunction

	function automatic logic is_inf(input logic [31:0] b);
		return (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
	endfunction

	function automatic logic is_zero(input logic [31:0] b);
		return b[30:0] == 31'd0;
	endfunction

	function automatic fin_t unpack(input logic [31:0] b);
		fin_t f;
		if (b[30:23] == 8'd0) begin
			f.sig = {1'b0, b[22:0]};
			f.e   = -12'sd149;
		end else begin
			f.sig = {1'b1, b[22:0]};
			f.e   = $signed({4'd0, b[30:23]}) - 12'sd150;
		end
		return f;
	endfunction

	// round sig * 2^e to binary32, nearest-even, subnormals kept
	function automatic logic [31:0] round_pack(input logic sign, input logic [63:0] sig,
			input logic signed [11:0] e);
		logic [6:0]         p;
		logic signed [11:0] shift;
		logic signed [11:0] lim;
		logic [127:0]       wide;
		logic [63:0]        q;
		logic               up;
		logic signed [11:0] be;
		p = 7'd0;
		for (int i = 0; i < 64; i++) begin
			if (sig[i]) p = 7'(i);
		end
		shift = $signed({5'd0, p}) - 12'sd23;
		lim = -12'sd149 - e;
		if (shift < lim) shift = lim;
		wide = 128'd0;
		up = 1'b0;
		if (shift <= 12'sd0) begin
			q = sig << 6'(-shift);
		end else if (shift > 12'sd127) begin
			q = 64'd0;
		end else begin
			wide = {sig, 64'd0} >> 7'(shift);
			q = wide[127:64];
			up = wide[63] && ((|wide[62:0]) || wide[64]);
			q = q + 64'(up);
		end
		if (q[24]) begin
			q = q >> 1;
			shift = shift + 12'sd1;
		end
		be = q[23] ? (e + shift + 12'sd150) : 12'sd0;
		if (sig == 64'd0) return {sign, 31'd0};
		if (be >= 12'sd255) return {sign, 8'hFF, 23'd0};
		return {sign, be[7:0], q[22:0]};
	endfunction

endpackage

// ----- hdl/fsa_mul.sv -----
`timescale 1ns / 1ps
// fsa_mul: binary32 multiply with round-to-nearest-even, combinational.
// Depends on fsa_pkg.
module fsa_mul (
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] y
);

	fsa_pkg::fin_t fa, fb;
	logic [47:0]   prod;
	logic          sgn;

	assign fa   = fsa_pkg::unpack(a);
	assign fb   = fsa_pkg::unpack(b);
	assign prod = fa.sig * fb.sig;
	assign sgn  = a[31] ^ b[31];

	always_comb begin
		if (fsa_pkg::is_nan(a) || fsa_pkg::is_nan(b)) begin
			y = fsa_pkg::QNAN;
		end else if (fsa_pkg::is_inf(a) || fsa_pkg::is_inf(b)) begin
			y = (fsa_pkg::is_zero(a) || fsa_pkg::is_zero(b)) ? fsa_pkg::QNAN
				: {sgn, 8'hFF, 23'd0};
		end else begin
			y = fsa_pkg::round_pack(sgn, {16'd0, prod}, fa.e + fb.e);
		end
	end

endmodule

// ----- hdl/fsa_add.sv -----
`timescale 1ns / 1ps
// fsa_add: binary32 add with round-to-nearest-even, combinational.
// Depends on fsa_pkg.
module fsa_add (
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] y
);

	fsa_pkg::fin_t fa, fb, big, lil;
	logic               sbig, slil;
	logic [11:0]        d;
	logic [5:0]         sh;
	logic [63:0]        av, bv, sum;
	logic signed [11:0] e;
	logic               rs;

	assign fa = fsa_pkg::unpack(a);
	assign fb = fsa_pkg::unpack(b);

	always_comb begin
		if (fa.e < fb.e) begin
			big = fb; lil = fa; sbig = b[31]; slil = a[31];
		end else begin
			big = fa; lil = fb; sbig = a[31]; slil = b[31];
		end
		d = 12'(big.e - lil.e);
		// far below the rounding point the smaller operand is only sticky
		if (d > 12'd39) begin
			sh = 6'd39;
			bv = {63'd0, lil.sig != 24'd0};
			e  = big.e - 12'sd39;
		end else begin
			sh = d[5:0];
			bv = {40'd0, lil.sig};
			e  = lil.e;
		end
		av = {40'd0, big.sig} << sh;
		if (sbig == slil) begin
			sum = av + bv; rs = sbig;
		end else if (av >= bv) begin
			sum = av - bv; rs = sbig;
		end else begin
			sum = bv - av; rs = slil;
		end

		if (fsa_pkg::is_nan(a) || fsa_pkg::is_nan(b)) begin
			y = fsa_pkg::QNAN;
		end else if (fsa_pkg::is_inf(a) && fsa_pkg::is_inf(b)) begin
			y = (a[31] == b[31]) ? a : fsa_pkg::QNAN;
		end else if (fsa_pkg::is_inf(a)) begin
			y = a;
		end else if (fsa_pkg::is_inf(b)) begin
			y = b;
		end else if (sum == 64'd0) begin
			y = {a[31] & b[31], 31'd0};
		end else begin
			y = fsa_pkg::round_pack(rs, sum, e);
		end
	end

endmodule

// ----- hdl/float_scale_offset.sv -----
`timescale 1ns / 1ps
// float_scale_offset: y = round(round(alpha*x) + beta) on binary32 items.
// One item per cycle while the pipe is not stalled.
// Stages: input register, product register (multiply), result register (add).
// The whole pipe stalls only while a result waits and result_ready is low.
// Async reset clears valids; scale resets to 1.0, offset to +0.0.
module float_scale_offset (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           element_valid,
	output logic                           element_ready,
	input  fsa_pkg::element_t              element,
	output logic                           result_valid,
	input  logic                           result_ready,
	output fsa_pkg::result_t               result,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [fsa_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [31:0]                    cfg_data
);

	logic [31:0] scale_q, offset_q;
	logic        valid_s1, valid_s2, out_valid_q;
	logic [31:0] x_s1, prod_s2, prod_c, sum_c;
	logic        last_s1, last_s2;
	fsa_pkg::result_t out_q;
	logic        adv;

	assign adv           = !out_valid_q || result_ready;
	assign element_ready = adv;
	assign cfg_ready     = 1'b1;
	assign result_valid  = out_valid_q;
	assign result        = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q  <= fsa_pkg::SCALE_RST;
			offset_q <= fsa_pkg::OFFSET_RST;
		end else if (cfg_valid) begin
			if (cfg_index == fsa_pkg::REG_SCALE) scale_q <= cfg_data;
			else if (cfg_index == fsa_pkg::REG_OFFSET) offset_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= element_valid;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1    <= element.element_value;
			last_s1 <= element.element_last;
			prod_s2 <= prod_c;
			last_s2 <= last_s1;
			out_q.result_value <= sum_c;
			out_q.result_last  <= last_s2;
		end
	end

	fsa_mul u_mul (.a(scale_q), .b(x_s1), .y(prod_c));
	fsa_add u_add (.a(prod_s2), .b(offset_q), .y(sum_c));

endmodule

// ----- hdl/fsa_checker.sv -----
`timescale 1ns / 1ps
// fsa_checker: port-level assertions for float_scale_offset, bound to the top level.
// Depends on fsa_pkg.
module fsa_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             element_ready,
	input logic             result_valid,
	input logic             result_ready,
	input fsa_pkg::result_t result,
	input logic             cfg_ready
);

	// pipe advances whenever the output slot is free or being drained
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		element_ready == (!result_valid || result_ready)) else $error("ready mismatch");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("stalled result changed");

	a_cfg: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("config port not ready");

endmodule

bind float_scale_offset fsa_checker u_fsa_checker (
	.clk(clk), .arst_n(arst_n), .element_ready(element_ready),
	.result_valid(result_valid), .result_ready(result_ready),
	.result(result), .cfg_ready(cfg_ready)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// testbench: self-checking bench for float_scale_offset (y = alpha*x + beta, binary32).
// Depends on fsa_pkg and hdl/float_scale_offset.sv; own bit-exact affine predictor.
module testbench;

	localparam logic [31:0] FP_POS_INF = 32'h7F80_0000;
	localparam logic [31:0] FP_NEG_INF = 32'hFF80_0000;
	localparam logic [31:0] FP_NEG_ZERO = 32'h8000_0000;
	localparam logic [fsa_pkg::CfgIdxW-1:0] REG_BOGUS = 8'd7;
	localparam int STALL_LIMIT = 4000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic element_valid = 1'b0;
	logic element_ready;
	fsa_pkg::element_t element = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	fsa_pkg::result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [fsa_pkg::CfgIdxW-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	float_scale_offset dut (
		.clk(clk), .arst_n(arst_n),
		.element_valid(element_valid), .element_ready(element_ready), .element(element),
		.result_valid(result_valid), .result_ready(result_ready), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	logic [31:0] alpha_bits, beta_bits;
	fsa_pkg::result_t pending_results[$];
	int errors = 0;
	int send_idle_pct = 0, recv_idle_pct = 0;
	bit hold_recv = 1'b0;
	int quiet_cycles = 0;

	function automatic bit fp_nan(logic [31:0] b);
		return b[30:23] == 8'hFF && b[22:0] != 0;
	endfunction
	function automatic bit fp_inf(logic [31:0] b);
		return b[30:23] == 8'hFF && b[22:0] == 0;
	endfunction

	// exact value sig*2^ex rounded nearest-even into binary32
	function automatic logic [31:0] to_binary32(bit sgn, logic [63:0] sig, int ex);
		int msb, sh, bexp;
		logic [63:0] q, rem, half;
		msb = 0;
		if (sig == 0) return {sgn, 31'd0};
		for (int i = 0; i < 64; i++) if (sig[i]) msb = i;
		sh = msb - 23;
		if (sh < -149 - ex) sh = -149 - ex;
		if (sh <= 0) q = sig << (-sh);
		else begin
			if (sh > 64) begin
				q = 0; rem = 1; half = 2;
			end else if (sh == 64) begin
				q = 0; rem = sig; half = 64'h8000_0000_0000_0000;
			end else begin
				q = sig >> sh;
				rem = sig & ((64'd1 << sh) - 1);
				half = 64'd1 << (sh - 1);
			end
			if (rem > half || (rem == half && q[0])) q++;
		end
		if (q >= 64'h100_0000) begin
			q = q >> 1;
			sh++;
		end
		bexp = (q >= 64'h80_0000) ? ex + sh + 150 : 0;
		if (bexp >= 255) return {sgn, 8'hFF, 23'd0};
		return {sgn, bexp[7:0], q[22:0]};
	endfunction

	function automatic void split(logic [31:0] b, output logic [63:0] sig, output int ex);
		if (b[30:23] == 0) begin
			sig = {41'd0, b[22:0]};
			ex = -149;
		end else begin
			sig = {40'd0, 1'b1, b[22:0]};
			ex = int'(b[30:23]) - 150;
		end
	endfunction

	function automatic logic [31:0] product_of(logic [31:0] a, logic [31:0] b);
		logic [63:0] ma, mb;
		int ea, eb;
		if (fp_nan(a) || fp_nan(b)) return fsa_pkg::QNAN;
		if (fp_inf(a) || fp_inf(b)) begin
			if (a[30:0] == 0 || b[30:0] == 0) return fsa_pkg::QNAN;
			return {a[31] ^ b[31], 8'hFF, 23'd0};
		end
		split(a, ma, ea);
		split(b, mb, eb);
		return to_binary32(a[31] ^ b[31], ma * mb, ea + eb);
	endfunction

	function automatic logic [31:0] sum_of(logic [31:0] a, logic [31:0] b);
		logic [63:0] ma, mb, av, bv, tot, tm;
		int ea, eb, d, ex;
		bit sa, sb, rs, tb;
		sa = a[31];
		sb = b[31];
		if (fp_nan(a) || fp_nan(b)) return fsa_pkg::QNAN;
		if (fp_inf(a) && fp_inf(b)) return (sa == sb) ? a : fsa_pkg::QNAN;
		if (fp_inf(a)) return a;
		if (fp_inf(b)) return b;
		split(a, ma, ea);
		split(b, mb, eb);
		if (ea < eb) begin
			tb = sa; sa = sb; sb = tb;
			tm = ma; ma = mb; mb = tm;
			d = ea; ea = eb; eb = d;
		end
		d = ea - eb;
		if (d > 39) begin
			av = ma << 39;
			bv = (mb != 0) ? 64'd1 : 64'd0;
			ex = ea - 39;
		end else begin
			av = ma << d;
			bv = mb;
			ex = eb;
		end
		if (sa == sb) begin
			tot = av + bv; rs = sa;
		end else if (av >= bv) begin
			tot = av - bv; rs = sa;
		end else begin
			tot = bv - av; rs = sb;
		end
		if (tot == 0) return (sa && sb) ? FP_NEG_ZERO : 32'd0;
		return to_binary32(rs, tot, ex);
	endfunction

	function automatic logic [31:0] affine_of(logic [31:0] x);
		return sum_of(product_of(alpha_bits, x), beta_bits);
	endfunction

	// special-heavy random pattern
	function automatic logic [31:0] rand_fp();
		logic [31:0] v;
		v = $urandom;
		case ($urandom_range(0, 9))
			0: v[30:23] = 8'hFF;
			1: v[30:23] = 8'h00;
			2: v[30:0] = ($urandom_range(0, 1) ? 31'd0 : 31'h7F80_0000);
			3: v[30:23] = 8'(120 + $urandom_range(0, 15));
			4: v[30:23] = 8'($urandom_range(0, 1) ? $urandom_range(240, 254) : $urandom_range(1, 10));
			default: ;
		endcase
		return v;
	endfunction

	task automatic write_reg(logic [fsa_pkg::CfgIdxW-1:0] idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == fsa_pkg::REG_SCALE) alpha_bits = val;
		else if (idx == fsa_pkg::REG_OFFSET) beta_bits = val;
		@(posedge clk);
	endtask

	// valid stays up between back-to-back items; it drops only on an idle cycle
	task automatic send_item(logic [31:0] x, bit last, bit known, logic [31:0] typed);
		fsa_pkg::result_t r;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			element_valid <= 1'b0;
			@(posedge clk);
		end
		r.result_value = known ? typed : affine_of(x);
		r.result_last = last;
		pending_results.push_back(r);
		element_valid <= 1'b1;
		element.element_value <= x;
		element.element_last <= last;
		do @(posedge clk); while (!element_ready);
	endtask

	task automatic drain();
		element_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic random_burst(int n);
		for (int i = 0; i < n; i++) send_item(rand_fp(), ($urandom_range(0, 7) == 0), 0, 0);
	endtask

	// receiver
	always @(posedge clk) begin
		if (result_valid && result_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: expected no result, actual %h", $time, result);
				errors++;
			end else begin
				fsa_pkg::result_t exp_r;
				exp_r = pending_results.pop_front();
				if (exp_r.result_value !== result.result_value) begin
					$display("%0t: value expected %h actual %h", $time,
						exp_r.result_value, result.result_value);
					errors++;
				end
				if (exp_r.result_last !== result.result_last) begin
					$display("%0t: last expected %0b actual %0b", $time,
						exp_r.result_last, result.result_last);
					errors++;
				end
			end
		end
		result_ready <= !hold_recv && ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// watchdog
	always @(posedge clk) begin
		if ((element_valid && element_ready) || (result_valid && result_ready) ||
				(cfg_valid && cfg_ready) || !arst_n)
			quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	typedef struct {
		logic [31:0] x;
		bit last;
		bit known;
		logic [31:0] y;
	} stim_row_t;

	stim_row_t directed[$];

	initial begin
		alpha_bits = fsa_pkg::SCALE_RST;
		beta_bits = fsa_pkg::OFFSET_RST;
		// reset state is identity-ish: alpha=1, beta=+0
		directed = '{
			'{32'h0000_0000, 0, 1, 32'h0000_0000},
			'{32'h8000_0000, 0, 1, 32'h0000_0000},
			'{32'h3F80_0000, 0, 1, 32'h3F80_0000},
			'{32'h7F80_0000, 0, 1, FP_POS_INF},
			'{32'hFF80_0000, 0, 1, FP_NEG_INF},
			'{32'h7FC0_1234, 0, 1, fsa_pkg::QNAN},
			'{32'hFF80_0001, 0, 1, fsa_pkg::QNAN},
			'{32'h7F7F_FFFF, 0, 0, 0},
			'{32'h0000_0001, 0, 0, 0},
			'{32'h807F_FFFF, 0, 0, 0},
			'{32'hFFFF_FFFF, 1, 1, fsa_pkg::QNAN},
			'{32'hC0A0_0000, 1, 0, 0}
		};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i]) send_item(directed[i].x, directed[i].last, directed[i].known,
			directed[i].y);
		drain();
		// overflow, inf*0, inf-inf, -0 + -0, underflow
		write_reg(fsa_pkg::REG_SCALE, 32'h7F7F_FFFF);
		write_reg(fsa_pkg::REG_OFFSET, FP_NEG_INF);
		write_reg(REG_BOGUS, 32'hDEAD_BEEF);
		send_item(32'h7F7F_FFFF, 0, 1, fsa_pkg::QNAN);
		send_item(32'h7F80_0000, 0, 1, fsa_pkg::QNAN);
		send_item(32'h0000_0000, 0, 1, FP_NEG_INF);
		send_item(32'h4000_0000, 1, 0, 0);
		drain();
		write_reg(fsa_pkg::REG_SCALE, FP_NEG_ZERO);
		write_reg(fsa_pkg::REG_OFFSET, FP_NEG_ZERO);
		send_item(32'h3F80_0000, 0, 1, FP_NEG_ZERO);
		send_item(32'hBF80_0000, 0, 1, 32'h0000_0000);
		send_item(32'h7F80_0000, 0, 1, fsa_pkg::QNAN);
		drain();
		write_reg(fsa_pkg::REG_SCALE, 32'h0000_0001);
		write_reg(fsa_pkg::REG_OFFSET, 32'h8000_0001);
		send_item(32'h3F00_0000, 0, 0, 0);
		send_item(32'h3FC0_0000, 1, 0, 0);
		send_item(32'h4040_0000, 0, 0, 0);
		drain();

		// idling phases with random settings; one long receiver hold-off
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 16 : (ph == 1) ? 79 : 0;
			recv_idle_pct = (ph == 0) ? 79 : (ph == 1) ? 16 : 0;
			for (int k = 0; k < 4; k++) begin
				write_reg(fsa_pkg::REG_SCALE,
					($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : rand_fp());
				write_reg(fsa_pkg::REG_OFFSET,
					($urandom_range(0, 3) == 0) ? 32'h0000_0000 : rand_fp());
				if (ph == 2 && k == 0) begin
					fork
						begin
							hold_recv = 1'b1;
							repeat (200) @(posedge clk);
							hold_recv = 1'b0;
						end
						random_burst(58);
					join
				end else random_burst(58);
				drain();
			end
		end

		if (errors == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end
endmodule

// ----- filelist.f -----
hdl/fsa_pkg.sv
hdl/fsa_mul.sv
hdl/fsa_add.sv
hdl/float_scale_offset.sv
hdl/fsa_checker.sv
tb/testbench.sv
